@@ src/pal_pkg.sv @@
`default_nettype none

package pal_pkg;

  // storage geometry
  localparam int unsigned DEPTH      = 64;
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned IDX_W      = $clog2(DEPTH);

  // fixed field widths
  localparam int unsigned POS_W   = 7;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned CAP_W   = 8;
  localparam int unsigned STEP_W  = 7;
  localparam int unsigned FOUND_W = 7;
  localparam int unsigned OP_W    = 3;
  localparam int unsigned STAT_W  = 2;

  // search and read tree: groups of cells reduced in the first cycle
  localparam int unsigned GROUP   = 8;
  localparam int unsigned GIDX_W  = $clog2(GROUP);
  localparam int unsigned NGROUP  = (DEPTH + GROUP - 1) / GROUP;
  localparam int unsigned NGRP_W  = (NGROUP > 1) ? $clog2(NGROUP) : 1;

  // increment register
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(8);
  localparam logic [STEP_W-1:0] STEP_MIN   = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_MAX   = STEP_W'(64);

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK    = STAT_W'(0);
  localparam logic [STAT_W-1:0] ST_RANGE = STAT_W'(1);
  localparam logic [STAT_W-1:0] ST_FULL  = STAT_W'(2);

  typedef enum logic [OP_W-1:0] {
    OP_GET    = 3'd0,
    OP_SET    = 3'd1,
    OP_INSERT = 3'd2,
    OP_DELETE = 3'd3,
    OP_SEARCH = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_SET,
    CMD_INS,
    CMD_DEL
  } cell_cmd_e;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_cmd_e        cmd;
    logic [POS_W-1:0] pos;
    logic [CNT_W-1:0] count;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ src/positional_array_list.sv @@
// Positional list of up to 64 signed 32-bit entries held in a chain of cells,
// one entry per cell. For get, set, insert, delete and search alike, in the
// accept cycle every cell shifts or writes at once and compares its entry
// with the operand, and the group results are registered; once the output
// register is free, the lowest hit and the read data are resolved and
// loaded into it. A new request is taken only after the previous one has
// been loaded into the output register, and is taken even while that result
// still waits there. Writing the increment register empties the list and
// sets the capacity to the increment (0 reads as 1, above 64 as 64); it is
// taken only while no request is in flight. Entries beyond the count are
// never reported.
`default_nettype none

module positional_array_list (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic        [pal_pkg::STEP_W-1:0]   grow_step_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic        [pal_pkg::OP_W-1:0]     opcode_i,
  input  wire logic        [pal_pkg::POS_W-1:0]    position_i,
  input  wire logic signed [31:0]                  operand_value_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed      [31:0]                  read_value_o,
  output logic signed      [pal_pkg::FOUND_W-1:0]  found_index_o,
  output logic             [pal_pkg::CNT_W-1:0]    entry_count_o,
  output logic             [pal_pkg::CAP_W-1:0]    logical_capacity_o,
  output logic             [pal_pkg::STAT_W-1:0]   status_o
);

  logic                                cfg_accept;
  logic                                in_accept;
  logic                                finish;
  logic                                busy_q;

  logic [pal_pkg::STEP_W-1:0]          step_q, step_d, step_cfg;
  logic [pal_pkg::CNT_W-1:0]           count_q, count_d;
  logic [pal_pkg::CAP_W-1:0]           cap_q, cap_d;
  logic [pal_pkg::CAP_W:0]             slack;
  logic                                in_range;
  pal_pkg::op_e                        op;
  pal_pkg::op_e                        op_q;
  logic [pal_pkg::STAT_W-1:0]          status_d, status_q;
  pal_pkg::cell_cmd_e                  cmd;
  pal_pkg::cell_ctrl_t                 ctrl;

  logic [pal_pkg::DEPTH-1:0][pal_pkg::VALUE_BITS-1:0] entry;
  logic [pal_pkg::DEPTH-1:0][pal_pkg::VALUE_BITS-1:0] pick;
  logic [pal_pkg::DEPTH-1:0]                          match;
  logic                                               col_hit;
  logic [pal_pkg::IDX_W-1:0]                          col_idx;
  logic [pal_pkg::VALUE_BITS-1:0]                     col_read;

  logic                                out_valid_q;
  logic [31:0]                         read_q;
  logic [pal_pkg::FOUND_W-1:0]         found_q;
  logic [pal_pkg::CNT_W-1:0]           cnt_out_q;
  logic [pal_pkg::CAP_W-1:0]           cap_out_q;
  logic [pal_pkg::STAT_W-1:0]          stat_out_q;

  // handshakes
  assign cfg_ready_o = !busy_q;
  assign in_ready_o  = !busy_q && !cfg_valid_i;
  assign cfg_accept  = cfg_valid_i && cfg_ready_o;
  assign in_accept   = in_valid_i && in_ready_o;
  assign finish      = busy_q && (!out_valid_q || out_ready_i);

  // increment clamp
  always_comb begin
    if (grow_step_i == '0) begin
      step_cfg = pal_pkg::STEP_MIN;
    end else if (grow_step_i > pal_pkg::STEP_MAX) begin
      step_cfg = pal_pkg::STEP_MAX;
    end else begin
      step_cfg = grow_step_i;
    end
  end

  assign op       = pal_pkg::op_e'(opcode_i);
  assign in_range = (position_i < count_q);
  assign slack    = {1'b0, cap_q} - (pal_pkg::CAP_W + 1)'(count_q - 1'b1);

  // request and config decode: status, cell command, count, capacity and increment update
  always_comb begin
    status_d = pal_pkg::ST_OK;
    cmd      = pal_pkg::CMD_HOLD;
    count_d  = count_q;
    cap_d    = cap_q;
    step_d   = step_q;
    if (cfg_accept) begin
      step_d  = step_cfg;
      count_d = '0;
      cap_d   = pal_pkg::CAP_W'(step_cfg);
    end else if (in_accept) begin
      unique case (op)
        pal_pkg::OP_GET: begin
          if (!in_range) status_d = pal_pkg::ST_RANGE;
        end
        pal_pkg::OP_SET: begin
          if (in_range) begin
            cmd = pal_pkg::CMD_SET;
          end else begin
            status_d = pal_pkg::ST_RANGE;
          end
        end
        pal_pkg::OP_INSERT: begin
          if (position_i > count_q) begin
            status_d = pal_pkg::ST_RANGE;
          end else if (count_q == pal_pkg::CNT_W'(pal_pkg::DEPTH)) begin
            status_d = pal_pkg::ST_FULL;
          end else begin
            cmd     = pal_pkg::CMD_INS;
            count_d = count_q + 1'b1;
            if (pal_pkg::CAP_W'(count_q) == cap_q) begin
              cap_d = cap_q + pal_pkg::CAP_W'(step_q);
            end
          end
        end
        pal_pkg::OP_DELETE: begin
          if (in_range) begin
            cmd     = pal_pkg::CMD_DEL;
            count_d = count_q - 1'b1;
            if ((cap_q >= pal_pkg::CAP_W'(count_d)) &&
                (slack == (pal_pkg::CAP_W + 1)'({step_q, 1'b0}))) begin
              cap_d = cap_q - pal_pkg::CAP_W'(step_q);
            end
          end else begin
            status_d = pal_pkg::ST_RANGE;
          end
        end
        pal_pkg::OP_SEARCH: begin
          status_d = pal_pkg::ST_OK;
        end
        default: begin
          status_d = pal_pkg::ST_OK;
        end
      endcase
    end
  end

  assign ctrl.cmd   = cmd;
  assign ctrl.pos   = position_i;
  assign ctrl.count = count_q;

  // chain of entry cells
  for (genvar i = 0; i < int'(pal_pkg::DEPTH); i++) begin : g_cell
    logic [pal_pkg::VALUE_BITS-1:0] left;
    logic [pal_pkg::VALUE_BITS-1:0] right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = entry[i-1];
    end
    if (i == int'(pal_pkg::DEPTH) - 1) begin : g_last
      assign right = entry[i];
    end else begin : g_mid_r
      assign right = entry[i+1];
    end
    pal_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .idx_i     (pal_pkg::IDX_W'(i)),
      .operand_i (pal_pkg::VALUE_BITS'(operand_value_i)),
      .left_i    (left),
      .right_i   (right),
      .entry_o   (entry[i]),
      .match_o   (match[i]),
      .pick_o    (pick[i])
    );
  end

  // search and read tree
  pal_collect u_collect (
    .clk_i     (clk_i),
    .capture_i (in_accept),
    .match_i   (match),
    .pick_i    (pick),
    .hit_o     (col_hit),
    .index_o   (col_idx),
    .read_o    (col_read)
  );

  // list state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= pal_pkg::STEP_RESET;
      count_q <= '0;
      cap_q   <= pal_pkg::CAP_W'(pal_pkg::STEP_RESET);
      busy_q  <= 1'b0;
    end else begin
      step_q  <= step_d;
      count_q <= count_d;
      cap_q   <= cap_d;
      if (in_accept) begin
        busy_q <= 1'b1;
      end else if (finish) begin
        busy_q <= 1'b0;
      end
    end
  end

  // request in flight
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q     <= op;
      status_q <= status_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      read_q     <= ((op_q == pal_pkg::OP_GET) && (status_q == pal_pkg::ST_OK)) ?
                    32'(col_read) : '0;
      if (op_q == pal_pkg::OP_SEARCH) begin
        found_q <= col_hit ? pal_pkg::FOUND_W'(col_idx) : '1;
      end else begin
        found_q <= '0;
      end
      cnt_out_q  <= count_q;
      cap_out_q  <= cap_q;
      stat_out_q <= status_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign read_value_o       = read_q;
  assign found_index_o      = found_q;
  assign entry_count_o      = cnt_out_q;
  assign logical_capacity_o = cap_out_q;
  assign status_o           = stat_out_q;

endmodule

`default_nettype wire

@@ src/pal_cell.sv @@
`default_nettype none

module pal_cell (
  input  wire logic                            clk_i,
  input  wire pal_pkg::cell_ctrl_t             ctrl_i,
  input  wire logic [pal_pkg::IDX_W-1:0]       idx_i,
  input  wire logic [pal_pkg::VALUE_BITS-1:0]  operand_i,
  input  wire logic [pal_pkg::VALUE_BITS-1:0]  left_i,
  input  wire logic [pal_pkg::VALUE_BITS-1:0]  right_i,
  output logic      [pal_pkg::VALUE_BITS-1:0]  entry_o,
  output logic                                 match_o,
  output logic      [pal_pkg::VALUE_BITS-1:0]  pick_o
);

  logic [pal_pkg::VALUE_BITS-1:0] entry_q, entry_d;
  logic                           at_pos;
  logic                           above;
  logic                           live;

  // where this cell sits relative to the request position and the fill
  assign at_pos = (ctrl_i.pos == pal_pkg::POS_W'(idx_i));
  assign above  = (pal_pkg::POS_W'(idx_i) > ctrl_i.pos);
  assign live   = (pal_pkg::CNT_W'(idx_i) < ctrl_i.count);

  // next entry: write, shift up from the left, or shift down from the right
  always_comb begin
    entry_d = entry_q;
    unique case (ctrl_i.cmd)
      pal_pkg::CMD_SET: begin
        if (at_pos) entry_d = operand_i;
      end
      pal_pkg::CMD_INS: begin
        if (above) begin
          entry_d = left_i;
        end else if (at_pos) begin
          entry_d = operand_i;
        end
      end
      pal_pkg::CMD_DEL: begin
        if (above || at_pos) entry_d = right_i;
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  // local compare and read select
  assign entry_o = entry_q;
  assign match_o = live && (entry_q == operand_i);
  assign pick_o  = at_pos ? entry_q : '0;

endmodule

`default_nettype wire

@@ src/pal_collect.sv @@
`default_nettype none

module pal_collect (
  input  wire logic                                                 clk_i,
  input  wire logic                                                 capture_i,
  input  wire logic [pal_pkg::DEPTH-1:0]                            match_i,
  input  wire logic [pal_pkg::DEPTH-1:0][pal_pkg::VALUE_BITS-1:0]   pick_i,
  output logic                                                      hit_o,
  output logic      [pal_pkg::IDX_W-1:0]                            index_o,
  output logic      [pal_pkg::VALUE_BITS-1:0]                       read_o
);

  localparam int unsigned PAD = pal_pkg::NGROUP * pal_pkg::GROUP;

  logic [PAD-1:0]                                     match_pad;
  logic [PAD-1:0][pal_pkg::VALUE_BITS-1:0]            pick_pad;
  logic [pal_pkg::NGROUP-1:0]                         grp_hit_d, grp_hit_q;
  logic [pal_pkg::NGROUP-1:0][pal_pkg::GIDX_W-1:0]    grp_idx_d, grp_idx_q;
  logic [pal_pkg::NGROUP-1:0][pal_pkg::VALUE_BITS-1:0] grp_read_d, grp_read_q;
  logic [pal_pkg::NGRP_W+pal_pkg::GIDX_W-1:0]         full_idx;

  // pad the cell row to whole groups
  always_comb begin
    match_pad = '0;
    pick_pad  = '0;
    for (int k = 0; k < int'(pal_pkg::DEPTH); k++) begin
      match_pad[k] = match_i[k];
      pick_pad[k]  = pick_i[k];
    end
  end

  // first level: per group hit, lowest matching slot and read data
  always_comb begin
    grp_hit_d  = '0;
    grp_idx_d  = '0;
    grp_read_d = '0;
    for (int g = 0; g < int'(pal_pkg::NGROUP); g++) begin
      for (int j = int'(pal_pkg::GROUP) - 1; j >= 0; j--) begin
        if (match_pad[g*pal_pkg::GROUP + j]) begin
          grp_hit_d[g] = 1'b1;
          grp_idx_d[g] = pal_pkg::GIDX_W'(j);
        end
        grp_read_d[g] = grp_read_d[g] | pick_pad[g*pal_pkg::GROUP + j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (capture_i) begin
      grp_hit_q  <= grp_hit_d;
      grp_idx_q  <= grp_idx_d;
      grp_read_q <= grp_read_d;
    end
  end

  // second level: lowest group that hit, merged read data
  always_comb begin
    hit_o    = |grp_hit_q;
    full_idx = '0;
    read_o   = '0;
    for (int g = int'(pal_pkg::NGROUP) - 1; g >= 0; g--) begin
      if (grp_hit_q[g]) full_idx = {pal_pkg::NGRP_W'(g), grp_idx_q[g]};
      read_o = read_o | grp_read_q[g];
    end
  end

  assign index_o = pal_pkg::IDX_W'(full_idx);

endmodule

`default_nettype wire

@@ src/pal_checker.sv @@
`default_nettype none

module pal_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                cfg_valid_i,
  input wire logic                                cfg_ready_o,
  input wire logic        [pal_pkg::STEP_W-1:0]   grow_step_i,
  input wire logic                                in_valid_i,
  input wire logic                                in_ready_o,
  input wire logic        [pal_pkg::OP_W-1:0]     opcode_i,
  input wire logic        [pal_pkg::POS_W-1:0]    position_i,
  input wire logic signed [31:0]                  operand_value_i,
  input wire logic                                out_valid_o,
  input wire logic                                out_ready_i,
  input wire logic signed [31:0]                  read_value_o,
  input wire logic signed [pal_pkg::FOUND_W-1:0]  found_index_o,
  input wire logic        [pal_pkg::CNT_W-1:0]    entry_count_o,
  input wire logic        [pal_pkg::CAP_W-1:0]    logical_capacity_o,
  input wire logic        [pal_pkg::STAT_W-1:0]   status_o
);

  // capacity never falls below the fill
  a_cap_covers_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (logical_capacity_o >= entry_count_o))
    else $error("capacity below entry count");

  // a full error only when every slot is used
  a_full_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == pal_pkg::ST_FULL)) |->
      (entry_count_o == pal_pkg::CNT_W'(pal_pkg::DEPTH)))
    else $error("full status with free slots");

  // failed requests report no data
  a_error_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != pal_pkg::ST_OK)) |->
      ((read_value_o == '0) && (found_index_o == '0)))
    else $error("data reported with error status");

  // a waiting result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(status_o) &&
      $stable(entry_count_o) && $stable(read_value_o)))
    else $error("result dropped while stalled");

endmodule

bind positional_array_list pal_checker u_pal_checker (.*);

`default_nettype wire
